### sv/lfu_pkg.sv
`default_nettype none
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 48;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE
    } t_state;

    // what one pass over the slots has found
    typedef struct packed {
        logic hit;
        logic victim_vld;
        logic free_vld;
    } t_scan_flags;

endpackage
`default_nettype wire

### sv/lfu_req_if.sv
`default_nettype none
interface lfu_req_if
    import lfu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;

    modport source (output valid, output req_type, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input req_type, input lookup_key, input write_value,
                    output ready);
endinterface
`default_nettype wire

### sv/lfu_rsp_if.sv
`default_nettype none
interface lfu_rsp_if
    import lfu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface
`default_nettype wire

### sv/lfu_cache_with_lru_tiebreak.sv
// LFU key/value cache with least-recently-used tie-break.
// Requests arrive on i_req (valid/ready): req_type selects get or put, with a
// 32-bit key and, for a put, a 32-bit value. Each request gives exactly one
// response beat on o_rsp: hit, read_value, evicted and evicted_key.
// The capacity register is written through i_cfg_we / i_cfg_wdata; the user
// writes it only while idle, which the block itself does not enforce; values
// above ENTRIES act as ENTRIES, zero makes puts do nothing. Entries live in a
// synchronous RAM. A request is taken in the idle state, then every slot is
// read once to find the hit, the eviction victim and the first empty slot; the
// last state drains the last read and the write state writes the entry back
// and loads the response register. One request is in flight at a time and the
// idle state takes the next one, so a new request waits until the last one is
// written back; the slot-by-slot scan comes from the single RAM read port.
// The response register frees the input side: a new request is taken while
// the last response waits. If the receiver holds ready low, the next write
// back waits in its final cycle until the response register is free.
// Reset (synchronous, active low) clears all valid bits, the occupancy, the
// use clock and the response valid, and sets the capacity to 16; the RAM
// itself is not cleared, so the block takes requests right after reset.
`default_nettype none
module lfu_cache_with_lru_tiebreak
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    lfu_req_if.sink               i_req,
    lfu_rsp_if.source             o_rsp
);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int DW    = KEY_W + VAL_W + COUNT_BITS + STAMP_BITS;
    localparam int CNT_LO = STAMP_BITS;
    localparam int VAL_LO = STAMP_BITS + COUNT_BITS;
    localparam int KEY_LO = STAMP_BITS + COUNT_BITS + VAL_W;
    localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [STAMP_BITS-1:0] r_clock, n_clock;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_out_valid;

    logic                  r_req_type;
    logic [KEY_W-1:0]      r_key;
    logic [VAL_W-1:0]      r_val;
    logic                  r_out_hit, n_out_hit;
    logic [VAL_W-1:0]      r_out_read_value, n_out_read_value;
    logic                  r_out_evicted, n_out_evicted;
    logic [KEY_W-1:0]      r_out_evicted_key, n_out_evicted_key;

    logic w_accept;
    logic w_out_free;
    logic w_in_ready;
    logic w_start;
    logic w_issue;
    logic w_commit;

    logic [DW-1:0] w_rdata;
    logic          w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [DW-1:0]    w_wdata;

    t_scan_flags           w_flags;
    logic [IDX_W-1:0]      w_hit_idx;
    logic [VAL_W-1:0]      w_hit_value;
    logic [COUNT_BITS-1:0] w_hit_count;
    logic [IDX_W-1:0]      w_victim_idx;
    logic [KEY_W-1:0]      w_victim_key;
    logic [IDX_W-1:0]      w_free_idx;

    logic [CMP_W-1:0]      w_cap_x;
    logic [CMP_W-1:0]      w_cap_eff;
    logic                  w_full;
    logic                  w_evict;
    logic [IDX_W-1:0]      w_ins_idx;
    logic [COUNT_BITS-1:0] w_cnt_inc;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_accept   = i_req.valid && w_in_ready;

    lfu_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (DW),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    lfu_scan #(
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_rd_vld       (r_rd_vld),
        .i_rd_idx       (r_rd_idx),
        .i_rd_ent_valid (r_valid[r_rd_idx]),
        .i_rd_key       (w_rdata[KEY_LO +: KEY_W]),
        .i_rd_value     (w_rdata[VAL_LO +: VAL_W]),
        .i_rd_count     (w_rdata[CNT_LO +: COUNT_BITS]),
        .i_rd_stamp     (w_rdata[0 +: STAMP_BITS]),
        .i_key          (r_key),
        .o_flags        (w_flags),
        .o_hit_idx      (w_hit_idx),
        .o_hit_value    (w_hit_value),
        .o_hit_count    (w_hit_count),
        .o_victim_idx   (w_victim_idx),
        .o_victim_key   (w_victim_key),
        .o_free_idx     (w_free_idx)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == IDX_LAST) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_start    = 1'b0;
        w_issue    = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                w_start    = 1'b1;
            end
            ST_SCAN: begin
                w_issue = 1'b1;
            end
            ST_LAST: begin
            end
            ST_WRITE: begin
                w_commit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    assign w_cap_x   = CMP_W'(r_cap);
    assign w_cap_eff = (w_cap_x > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : w_cap_x;
    assign w_full    = CMP_W'(r_occ) >= w_cap_eff;
    assign w_evict   = w_full && w_flags.victim_vld;
    // an insert takes the lowest empty slot, counting the one just evicted
    assign w_ins_idx = (w_evict && (!w_flags.free_vld || (w_victim_idx < w_free_idx))) ?
                       w_victim_idx : w_free_idx;
    assign w_cnt_inc = (w_hit_count == CNT_MAX) ? w_hit_count : w_hit_count + CNT_ONE;

    always_comb begin
        w_we              = 1'b0;
        w_waddr           = w_hit_idx;
        w_wdata           = {r_key, r_val, w_cnt_inc, r_clock};
        n_valid           = r_valid;
        n_occ             = r_occ;
        n_clock           = r_clock;
        n_out_hit         = w_flags.hit;
        n_out_read_value  = '0;
        n_out_evicted     = 1'b0;
        n_out_evicted_key = '0;
        if (r_req_type == REQ_GET) begin
            if (w_flags.hit) begin
                w_we             = 1'b1;
                w_wdata          = {r_key, w_hit_value, w_cnt_inc, r_clock};
                n_clock          = r_clock + STAMP_BITS'(1);
                n_out_read_value = w_hit_value;
            end
        end else if (w_cap_eff != '0) begin
            w_we    = 1'b1;
            n_clock = r_clock + STAMP_BITS'(1);
            if (!w_flags.hit) begin
                w_waddr = w_ins_idx;
                w_wdata = {r_key, r_val, CNT_ONE, r_clock};
                if (w_evict) begin
                    n_valid[w_victim_idx] = 1'b0;
                    n_out_evicted         = 1'b1;
                    n_out_evicted_key     = w_victim_key;
                end else begin
                    n_occ = r_occ + OCC_W'(1);
                end
                n_valid[w_ins_idx] = 1'b1;
            end
        end
        if (!w_commit) begin
            w_we    = 1'b0;
            n_valid = r_valid;
            n_occ   = r_occ;
            n_clock = r_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_clock     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            r_valid  <= n_valid;
            r_occ    <= n_occ;
            r_clock  <= n_clock;
            if (w_accept) begin
                r_idx <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_accept) begin
            r_req_type <= i_req.req_type;
            r_key      <= i_req.lookup_key;
            r_val      <= i_req.write_value;
        end
        if (w_commit) begin
            r_out_hit         <= n_out_hit;
            r_out_read_value  <= n_out_read_value;
            r_out_evicted     <= n_out_evicted;
            r_out_evicted_key <= n_out_evicted_key;
        end
    end

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_read_value;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_evicted_key;
endmodule
`default_nettype wire

### sv/lfu_mem.sv
`default_nettype none
module lfu_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 128,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### sv/lfu_scan.sv
`default_nettype none
module lfu_scan
    import lfu_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int COUNT_BITS = 16,
    parameter int STAMP_BITS = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_rd_vld,
    input  wire logic [IDX_W-1:0]      i_rd_idx,
    input  wire logic                  i_rd_ent_valid,
    input  wire logic [KEY_W-1:0]      i_rd_key,
    input  wire logic [VAL_W-1:0]      i_rd_value,
    input  wire logic [COUNT_BITS-1:0] i_rd_count,
    input  wire logic [STAMP_BITS-1:0] i_rd_stamp,
    input  wire logic [KEY_W-1:0]      i_key,
    output t_scan_flags                o_flags,
    output logic      [IDX_W-1:0]      o_hit_idx,
    output logic      [VAL_W-1:0]      o_hit_value,
    output logic      [COUNT_BITS-1:0] o_hit_count,
    output logic      [IDX_W-1:0]      o_victim_idx,
    output logic      [KEY_W-1:0]      o_victim_key,
    output logic      [IDX_W-1:0]      o_free_idx
);
    t_scan_flags           r_flags;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [VAL_W-1:0]      r_hit_value;
    logic [COUNT_BITS-1:0] r_hit_count;
    logic [IDX_W-1:0]      r_victim_idx;
    logic [KEY_W-1:0]      r_victim_key;
    logic [COUNT_BITS-1:0] r_victim_count;
    logic [STAMP_BITS-1:0] r_victim_stamp;
    logic [IDX_W-1:0]      r_free_idx;

    logic w_live;
    logic w_match;
    logic w_older;

    assign w_live  = i_rd_vld && i_rd_ent_valid;
    assign w_match = w_live && (i_rd_key == i_key);
    // strict compare keeps the lowest slot on a full tie
    assign w_older = !r_flags.victim_vld || (i_rd_count < r_victim_count) ||
                     ((i_rd_count == r_victim_count) && (i_rd_stamp < r_victim_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else begin
            if (w_match) begin
                r_flags.hit <= 1'b1;
            end
            if (w_live && w_older) begin
                r_flags.victim_vld <= 1'b1;
            end
            if (i_rd_vld && !i_rd_ent_valid) begin
                r_flags.free_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match) begin
            r_hit_idx   <= i_rd_idx;
            r_hit_value <= i_rd_value;
            r_hit_count <= i_rd_count;
        end
        if (w_live && w_older) begin
            r_victim_idx   <= i_rd_idx;
            r_victim_key   <= i_rd_key;
            r_victim_count <= i_rd_count;
            r_victim_stamp <= i_rd_stamp;
        end
        // keep the first empty slot only
        if (i_rd_vld && !i_rd_ent_valid && !r_flags.free_vld) begin
            r_free_idx <= i_rd_idx;
        end
    end

    assign o_flags      = r_flags;
    assign o_hit_idx    = r_hit_idx;
    assign o_hit_value  = r_hit_value;
    assign o_hit_count  = r_hit_count;
    assign o_victim_idx = r_victim_idx;
    assign o_victim_key = r_victim_key;
    assign o_free_idx   = r_free_idx;
endmodule
`default_nettype wire

### sv/lfu_chk.sv
`default_nettype none
module lfu_chk
    import lfu_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire logic             i_rsp_hit,
    input wire logic [VAL_W-1:0] i_rsp_read_value,
    input wire logic             i_rsp_evicted,
    input wire logic [KEY_W-1:0] i_rsp_evicted_key
);
    // an eviction only follows a miss: it is never reported together with a hit
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_evicted && i_rsp_hit))
        else $error("eviction reported on a hit");

    a_value_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_read_value != '0)) |-> i_rsp_hit)
        else $error("read value without a hit");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_evicted) |-> (i_rsp_evicted_key == '0))
        else $error("evicted key set without eviction");

    // one request in flight: ready drops after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("second request taken while busy");

    // hold a stalled response beat unchanged
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_read_value) &&
             $stable(i_rsp_evicted) && $stable(i_rsp_evicted_key)))
        else $error("response beat changed while stalled");
endmodule

bind lfu_cache_with_lru_tiebreak lfu_chk u_lfu_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_hit         (o_rsp.hit),
    .i_rsp_read_value  (o_rsp.read_value),
    .i_rsp_evicted     (o_rsp.evicted),
    .i_rsp_evicted_key (o_rsp.evicted_key)
);
`default_nettype wire
